[hw/rtl/lfd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the length-prefixed frame decoder.
// No dependencies; every other file in this block refers to it.
package lfd_pkg;

    localparam int unsigned MAX_W = 17;
    localparam logic [MAX_W-1:0] MAX_FRAME_RESET = 17'd4096;
    localparam logic [MAX_W-1:0] LEN_FIELD_BYTES = 17'd2;

    typedef enum logic [0:0] {
        CMD_DATA  = 1'b0,
        CMD_RESET = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2,
        KIND_EMPTY   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_LEN_HI  = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_TYPE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_HOLD    = 3'd4
    } phase_t;

    typedef struct packed {
        logic [0:0] cmd;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  frame_type;
        logic [15:0] body_len;
        logic [7:0]  payload_byte;
        logic        last;
    } result_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  frame_type;
        logic [15:0] value;
        logic        last;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

[hw/rtl/lfd_front.sv]
`timescale 1ns / 1ps
// Front end: accepts stream bytes, tracks the frame phase and classifies each byte.
// Depends on lfd_pkg; pushes result operations into lfd_queue.
module lfd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lfd_pkg::MAX_W-1:0]     cfg_wr_data,
    input  logic                          item_valid,
    input  lfd_pkg::item_t                item,
    input  logic                          q_full,
    output logic                          accept,
    output logic                          push,
    output lfd_pkg::op_t                  push_op,
    output lfd_pkg::phase_t               phase
);

    lfd_pkg::phase_t             phase_reg, phase_next;
    logic [15:0]                 length_reg, length_next;
    logic [15:0]                 left_reg, left_next;
    logic [7:0]                  type_reg, type_next;
    logic [lfd_pkg::MAX_W-1:0]   max_reg;
    logic [15:0]                 length_lo_w;
    logic [15:0]                 length_m1;
    logic                        oversize;
    logic                        is_reset;
    logic                        fin;

    assign accept      = item_valid && !q_full;
    assign is_reset    = (item.cmd == lfd_pkg::CMD_RESET);
    assign length_lo_w = {length_reg[15:8], item.data_byte};
    assign oversize    = ({1'b0, length_lo_w} + lfd_pkg::LEN_FIELD_BYTES) > max_reg;
    assign length_m1   = length_reg - 16'd1;
    assign fin         = (left_reg <= 16'd1);
    assign phase       = phase_reg;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (is_reset)
            begin
                phase_next = lfd_pkg::PH_LEN_HI;
            end
            else
            begin
                unique case (phase_reg)
                    lfd_pkg::PH_LEN_HI:  phase_next = lfd_pkg::PH_LEN_LO;
                    lfd_pkg::PH_LEN_LO:
                    begin
                        if (oversize)
                            phase_next = lfd_pkg::PH_HOLD;
                        else if (length_lo_w == 16'd0)
                            phase_next = lfd_pkg::PH_LEN_HI;
                        else
                            phase_next = lfd_pkg::PH_TYPE;
                    end
                    lfd_pkg::PH_TYPE:
                        phase_next = (length_m1 == 16'd0) ? lfd_pkg::PH_LEN_HI
                                                          : lfd_pkg::PH_PAYLOAD;
                    lfd_pkg::PH_PAYLOAD:
                        phase_next = fin ? lfd_pkg::PH_LEN_HI : lfd_pkg::PH_PAYLOAD;
                    lfd_pkg::PH_HOLD:    phase_next = lfd_pkg::PH_HOLD;
                    default:             phase_next = lfd_pkg::PH_LEN_LO;
                endcase
            end
        end
    end

    always_comb
    begin
        length_next        = length_reg;
        left_next          = left_reg;
        type_next          = type_reg;
        push               = 1'b0;
        push_op.kind       = lfd_pkg::KIND_HEADER;
        push_op.frame_type = 8'd0;
        push_op.value      = 16'd0;
        push_op.last       = 1'b1;
        if (accept)
        begin
            if (is_reset)
            begin
                length_next = 16'd0;
                left_next   = 16'd0;
                type_next   = 8'd0;
            end
            else
            begin
                unique case (phase_reg)
                    lfd_pkg::PH_LEN_HI:
                        length_next = {item.data_byte, 8'd0};
                    lfd_pkg::PH_LEN_LO:
                    begin
                        length_next = length_lo_w;
                        if (oversize)
                        begin
                            push         = 1'b1;
                            push_op.kind = lfd_pkg::KIND_ERROR;
                        end
                        else if (length_lo_w == 16'd0)
                        begin
                            push         = 1'b1;
                            push_op.kind = lfd_pkg::KIND_EMPTY;
                        end
                    end
                    lfd_pkg::PH_TYPE:
                    begin
                        type_next          = item.data_byte;
                        left_next          = length_m1;
                        push               = 1'b1;
                        push_op.kind       = lfd_pkg::KIND_HEADER;
                        push_op.frame_type = item.data_byte;
                        push_op.value      = length_m1;
                        push_op.last       = (length_m1 == 16'd0);
                    end
                    lfd_pkg::PH_PAYLOAD:
                    begin
                        left_next          = fin ? 16'd0 : (left_reg - 16'd1);
                        push               = 1'b1;
                        push_op.kind       = lfd_pkg::KIND_PAYLOAD;
                        push_op.frame_type = type_reg;
                        push_op.value      = {8'd0, item.data_byte};
                        push_op.last       = fin;
                    end
                    lfd_pkg::PH_HOLD:
                    begin
                        push = 1'b0;
                    end
                    default:
                        length_next = {item.data_byte, 8'd0};
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lfd_pkg::PH_LEN_HI;
            length_reg <= 16'd0;
            left_reg   <= 16'd0;
            type_reg   <= 8'd0;
            max_reg    <= lfd_pkg::MAX_FRAME_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            left_reg   <= left_next;
            type_reg   <= type_next;
            if (cfg_wr_en)
                max_reg <= cfg_wr_data;
        end
    end

endmodule

[hw/rtl/lfd_queue.sv]
`timescale 1ns / 1ps
// Small first-in first-out queue of result operations between front and back.
// Depends on lfd_pkg for the operation type.
module lfd_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lfd_pkg::op_t         push_op,
    input  logic                 pop,
    output lfd_pkg::op_t         head_op,
    output lfd_pkg::queue_stat_t stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lfd_pkg::op_t     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

[hw/rtl/lfd_back.sv]
`timescale 1ns / 1ps
// Back end: pops result operations, formats result fields and holds the output register.
// Depends on lfd_pkg; fed by lfd_queue.
module lfd_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfd_pkg::queue_stat_t q_stat,
    input  lfd_pkg::op_t         head_op,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output lfd_pkg::result_t     result
);

    logic             valid_reg, valid_next;
    lfd_pkg::result_t result_reg, result_next;

    assign pop          = !q_stat.empty && (!valid_reg || !result_stall);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        result_next.kind         = head_op.kind;
        result_next.frame_type   = 8'd0;
        result_next.body_len     = 16'd0;
        result_next.payload_byte = 8'd0;
        result_next.last         = head_op.last;
        unique case (head_op.kind)
            lfd_pkg::KIND_HEADER:
            begin
                result_next.frame_type = head_op.frame_type;
                result_next.body_len   = head_op.value;
            end
            lfd_pkg::KIND_PAYLOAD:
            begin
                result_next.frame_type   = head_op.frame_type;
                result_next.payload_byte = head_op.value[7:0];
            end
            lfd_pkg::KIND_ERROR, lfd_pkg::KIND_EMPTY:
            begin
                result_next.last = 1'b1;
            end
            default:
            begin
                result_next.last = head_op.last;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (!result_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= result_next;
    end

endmodule

[hw/rtl/length_prefixed_frame_decoder.sv]
`timescale 1ns / 1ps
// Top level of the length-prefixed frame decoder: front end, queue and back end.
// Depends on lfd_pkg, lfd_front, lfd_queue and lfd_back.
//
//   Channel  Direction  Handshake                 Payload
//   item     in         item_valid / item_stall   lfd_pkg::item_t (cmd, data_byte)
//   result   out        result_valid / result_stall  lfd_pkg::result_t
//   cfg      in         cfg_wr_en                 cfg_wr_data (max_frame_bytes)
//
// One byte transfer is accepted per cycle while the queue has room.
// A result is registered in the queue entry and then in the output register after its byte transfer.
// The input stalls only when the queue is full; depth is QUEUE_DEPTH entries.
// Reset clears the frame phase, counters, queue and output valid; max_frame_bytes resets to 4096.
module length_prefixed_frame_decoder
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lfd_pkg::MAX_W-1:0]     cfg_wr_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  lfd_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output lfd_pkg::result_t              result
);

    logic                 accept;
    logic                 push;
    logic                 pop;
    lfd_pkg::op_t         push_op;
    lfd_pkg::op_t         head_op;
    lfd_pkg::queue_stat_t q_stat;
    lfd_pkg::phase_t      phase;

    assign item_stall = q_stat.full;

    lfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .q_full      (q_stat.full),
        .accept      (accept),
        .push        (push),
        .push_op     (push_op),
        .phase       (phase)
    );

    lfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .stat    (q_stat)
    );

    lfd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head_op      (head_op),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.cmd == lfd_pkg::CMD_RESET) |=> (phase == lfd_pkg::PH_LEN_HI))
        else $error("Session reset did not return the phase to the length high byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.cmd == lfd_pkg::CMD_DATA) && (phase == lfd_pkg::PH_HOLD)
        |-> !push ##1 (phase == lfd_pkg::PH_HOLD))
        else $error("A data byte left the error hold or produced a result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((result.kind == lfd_pkg::KIND_ERROR)
                         || (result.kind == lfd_pkg::KIND_EMPTY))
        |-> result.last && (result.frame_type == 8'd0) && (result.body_len == 16'd0))
        else $error("Error or empty-frame result carries frame fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !accept |-> 1'b0)
        else $error("Queue push without an accepted transfer.");

endmodule

[verif/length_prefixed_frame_decoder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for length_prefixed_frame_decoder: directed and random byte streams.
// Depends on lfd_pkg and the decoder RTL; a scoreboard class predicts every result transfer.
module length_prefixed_frame_decoder_tb;
    import lfd_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 1700;

    class frame_scoreboard;
        logic [MAX_W-1:0] max_bytes = MAX_FRAME_RESET;
        phase_t ph = PH_LEN_HI;
        logic [15:0] length_value = '0;
        logic [15:0] bytes_left = '0;
        logic [7:0] frame_type = '0;
        result_t expected_results[$];
        int live_items = 0;
        int errors = 0;

        function void clear_frame();
            ph = PH_LEN_HI;
            length_value = '0;
            bytes_left = '0;
            frame_type = '0;
        endfunction

        function void predict(item_t it);
            result_t r;
            r = '0;
            if (ph != PH_HOLD || it.cmd == CMD_RESET)
            begin
                live_items++;
            end
            if (it.cmd == CMD_RESET)
            begin
                clear_frame();
                return;
            end
            case (ph)
                PH_LEN_LO:
                begin
                    length_value[7:0] = it.data_byte;
                    if ({1'b0, length_value} + LEN_FIELD_BYTES > max_bytes)
                    begin
                        ph = PH_HOLD;
                        r.kind = KIND_ERROR;
                        r.last = 1'b1;
                        expected_results.push_back(r);
                    end
                    else if (length_value == 16'd0)
                    begin
                        ph = PH_LEN_HI;
                        r.kind = KIND_EMPTY;
                        r.last = 1'b1;
                        expected_results.push_back(r);
                    end
                    else
                    begin
                        ph = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    frame_type = it.data_byte;
                    bytes_left = length_value - 16'd1;
                    ph = (bytes_left == 16'd0) ? PH_LEN_HI : PH_PAYLOAD;
                    r.kind = KIND_HEADER;
                    r.frame_type = frame_type;
                    r.body_len = bytes_left;
                    r.last = (bytes_left == 16'd0);
                    expected_results.push_back(r);
                end
                PH_PAYLOAD:
                begin
                    r.kind = KIND_PAYLOAD;
                    r.frame_type = frame_type;
                    r.payload_byte = it.data_byte;
                    r.last = (bytes_left <= 16'd1);
                    if (r.last)
                    begin
                        bytes_left = '0;
                        ph = PH_LEN_HI;
                    end
                    else
                    begin
                        bytes_left = bytes_left - 16'd1;
                    end
                    expected_results.push_back(r);
                end
                PH_HOLD:
                begin
                end
                default:
                begin
                    length_value = {it.data_byte, 8'h00};
                    ph = PH_LEN_LO;
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        task compare(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result transfer %h with nothing expected", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
            begin
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            end
            if (got.frame_type !== want.frame_type)
            begin
                report($sformatf("frame_type %h, expected %h", got.frame_type, want.frame_type));
            end
            if (got.body_len !== want.body_len)
            begin
                report($sformatf("body_len %0d, expected %0d",
                                 got.body_len, want.body_len));
            end
            if (got.payload_byte !== want.payload_byte)
            begin
                report($sformatf("payload_byte %h, expected %h",
                                 got.payload_byte, want.payload_byte));
            end
            if (got.last !== want.last)
            begin
                report($sformatf("last %b, expected %b", got.last, want.last));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [MAX_W-1:0] cfg_wr_data;
    logic item_valid;
    logic item_stall;
    item_t item;
    logic result_valid;
    logic result_stall;
    result_t result;

    frame_scoreboard sb = new;
    bit no_idle = 1'b0;
    int limit_now = 4096;
    int idle_cycles = 0;
    int stall_left = 0;
    int flow_left = 0;

    item_t script[] = '{
        {CMD_DATA, 8'h00}, {CMD_DATA, 8'h01}, {CMD_DATA, 8'hFF},
        {CMD_DATA, 8'h00}, {CMD_DATA, 8'h00},
        {CMD_DATA, 8'h00}, {CMD_DATA, 8'h03}, {CMD_DATA, 8'h00}, {CMD_DATA, 8'hFF},
        {CMD_DATA, 8'h00},
        {CMD_DATA, 8'h00}, {CMD_DATA, 8'h05}, {CMD_DATA, 8'hA5}, {CMD_DATA, 8'h3C},
        {CMD_RESET, 8'hFF},
        {CMD_DATA, 8'h0F}, {CMD_DATA, 8'hFF}, {CMD_DATA, 8'hFF}, {CMD_DATA, 8'h00},
        {CMD_RESET, 8'h00},
        {CMD_DATA, 8'hFF}, {CMD_DATA, 8'hFF}, {CMD_RESET, 8'h5A}
    };

    length_prefixed_frame_decoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
            if (flow_left > 0)
            begin
                flow_left--;
            end
            else
            begin
                flow_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(0, 6);
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            sb.predict(item);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            sb.compare(result);
        end
        if (rst_n && ((item_valid && !item_stall) || (result_valid && !result_stall)))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("length_prefixed_frame_decoder_tb: FAIL");
            $finish;
        end
    end

    // Entered and left at a falling edge; valid stays high so back-to-back transfers need no gap.
    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item({CMD_DATA, b});
    endtask

    task automatic send_session_reset();
        send_item({CMD_RESET, 8'($urandom)});
    endtask

    // keep limits how many bytes after the length field are sent; a cut frame ends in a
    // session reset.
    task automatic send_frame(input logic [15:0] len, input int keep);
        int body;
        int i;
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (int'(len) + int'(LEN_FIELD_BYTES) > limit_now)
        begin
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            send_session_reset();
        end
        else if (len != 16'd0)
        begin
            body = (keep < 0 || keep > int'(len)) ? int'(len) : keep;
            for (i = 0; i < body; i++)
            begin
                send_byte(8'($urandom));
            end
            if (body < int'(len))
            begin
                send_session_reset();
            end
        end
    endtask

    task automatic send_random_frame();
        int r;
        int s;
        int n;
        int keep;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            send_session_reset();
            return;
        end
        if (r < 10)
        begin
            send_session_reset();
            return;
        end
        s = $urandom_range(0, 99);
        if (s < 8)
        begin
            n = 0;
        end
        else if (s < 16)
        begin
            n = 1;
        end
        else if (s < 70)
        begin
            n = $urandom_range(2, 24);
        end
        else if (s < 80)
        begin
            n = limit_now - 2;
            if (n > 300)
            begin
                n = $urandom_range(2, 24);
            end
        end
        else if (s < 88)
        begin
            n = limit_now - 1;
            if (n > 65535)
            begin
                n = $urandom_range(2, 24);
            end
        end
        else
        begin
            n = $urandom_range(0, 65535);
            if (n + 2 <= limit_now && n > 300)
            begin
                n = n % 25;
            end
        end
        keep = (n > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
        send_frame(16'(n), keep);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_max_frame(input int v);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= MAX_W'(v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.max_bytes = MAX_W'(v);
        limit_now = v;
    endtask

    initial
    begin
        int i;
        int phase_no;
        int v;
        int stop_at;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < script.size(); i++)
        begin
            send_item(script[i]);
        end

        phase_no = 0;
        while (sb.live_items < script.size() + RANDOM_ITEMS)
        begin
            case (phase_no % 6)
                0: v = 3;
                1: v = 65537;
                2: v = $urandom_range(3, 40);
                3: v = int'(MAX_FRAME_RESET);
                4: v = $urandom_range(41, 600);
                default: v = $urandom_range(3, 65537);
            endcase
            write_max_frame(v);
            no_idle = (phase_no % 4 == 3);
            stop_at = sb.live_items + 200;
            if (stop_at > script.size() + RANDOM_ITEMS)
            begin
                stop_at = script.size() + RANDOM_ITEMS;
            end
            while (sb.live_items < stop_at)
            begin
                send_random_frame();
            end
            phase_no++;
        end

        // The start of a frame of the largest length the field allows, cut short.
        write_max_frame(65537);
        no_idle = 1'b1;
        send_frame(16'hFFFF, 20);
        no_idle = 1'b0;
        settle();

        if (sb.errors == 0)
        begin
            $display("length_prefixed_frame_decoder_tb: PASS");
        end
        else
        begin
            $display("length_prefixed_frame_decoder_tb: FAIL");
        end
        $finish;
    end
endmodule
